### src/ssm_pkg.sv
// Shared constants, types and arithmetic helpers of the separable smoothing filter.
package ssm_pkg;

  localparam int VERT_TAPS    = 7;
  localparam int HORIZ_TAPS   = 5;
  localparam int VHALF        = 3;
  localparam int HHALF        = 2;
  localparam int LINE_ROWS    = 6;
  localparam int SAMP_W       = 12;
  localparam int PIX_W        = 16;
  localparam int TAP_W        = 16;
  localparam int DIM_W        = 11;
  localparam int BANK_W       = 3;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 64;
  localparam int DEF_MAX_COLS = 1024;
  localparam int DEF_MAX_ROWS = 1024;
  localparam int IN_Q_DEPTH   = 4;
  localparam int OUT_Q_DEPTH  = 8;
  localparam int VPROD_W      = 29;
  localparam int VPART_W      = 31;
  localparam int VSUM_W       = 32;
  localparam int HPROD_W      = 32;
  localparam int HSUM_W       = 35;
  localparam int ACC_W        = 36;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_ROWS     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_COLS     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_VERT_TAPS_LO   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_VERT_TAPS_HI   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_HORIZ_TAPS_LO  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_HORIZ_TAP_FOUR = 3'd5;

  localparam logic [DIM_W-1:0] RST_FRAME_ROWS  = 11'd480;
  localparam logic [DIM_W-1:0] RST_FRAME_COLS  = 11'd640;
  localparam logic [63:0]      RST_VERT_LO     = 64'h4000_0000_0000_0000;
  localparam logic [47:0]      RST_VERT_HI     = 48'h0;
  localparam logic [63:0]      RST_HORIZ_LO    = 64'h0000_4000_0000_0000;
  localparam logic [15:0]      RST_HORIZ_FOUR  = 16'h0;

  localparam logic [1:0] VM_ZERO = 2'd0;
  localparam logic [1:0] VM_EDGE = 2'd1;
  localparam logic [1:0] VM_FILT = 2'd2;

  typedef struct packed {
    logic              wr;
    logic [BANK_W-1:0] bank;
    logic [1:0]        vmode;
    logic              emit;
    logic              hedge;
    logic              last;
  } ctl_t;

  function automatic logic [BANK_W-1:0] bank_add(logic [BANK_W-1:0] b, logic [BANK_W-1:0] k);
    logic [BANK_W:0] s;
    s = {1'b0, b} + {1'b0, k};
    if (s >= (BANK_W+1)'(LINE_ROWS)) s = s - (BANK_W+1)'(LINE_ROWS);
    return s[BANK_W-1:0];
  endfunction

  function automatic logic signed [PIX_W-1:0] round_sat(logic signed [ACC_W-1:0] acc);
    logic signed [ACC_W:0] t;
    logic signed [22:0]    q;
    t = (ACC_W+1)'(acc) + 37'sd8192;
    q = 23'(t >>> 14);
    if (q > 23'sd32767) return 16'sh7fff;
    if (q < -23'sd32768) return 16'sh8000;
    return q[PIX_W-1:0];
  endfunction

endpackage

### src/ssm_fifo.sv
// Small synchronous queue with combinational head read.
module ssm_fifo
  import ssm_pkg::*;
#(
  parameter int W     = 8,
  parameter int DEPTH = 4
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  input  logic [W-1:0]               push_data,
  input  logic                       pop,
  output logic [W-1:0]               head,
  output logic [$clog2(DEPTH+1)-1:0] count,
  output logic                       full,
  output logic                       empty
);
  localparam int PW = $clog2(DEPTH);

  logic [W-1:0]  store [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;

  assign head  = store[rd_ptr];
  assign full  = count == ($clog2(DEPTH+1))'(DEPTH);
  assign empty = count == '0;

  always_ff @(posedge clk) begin
    if (push) store[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + PW'(1);
      if (pop) rd_ptr <= rd_ptr + PW'(1);
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end
endmodule

### src/ssm_front.sv
// Front end: raster position tracking and classification of each accepted item.
module ssm_front
  import ssm_pkg::*;
#(
  parameter int MAX_COLS = DEF_MAX_COLS,
  parameter int MAX_ROWS = DEF_MAX_ROWS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          restart,
  input  logic [DIM_W-1:0]              frame_rows,
  input  logic [DIM_W-1:0]              frame_cols,
  input  logic                          accept,
  input  logic                          req_type,
  output logic                          push,
  output ctl_t                          ctl,
  output logic [$clog2(MAX_COLS)-1:0]   col
);
  localparam int CW = $clog2(MAX_COLS);
  localparam int RW = $clog2(MAX_ROWS + 8);

  logic [CW-1:0]     in_col;
  logic [RW-1:0]     in_row;
  logic [BANK_W-1:0] bank;
  logic [CW-1:0]     out_col;
  logic [RW-1:0]     out_row;

  logic [31:0]   rq;
  logic [31:0]   cq;
  logic [RW-1:0] rows;
  logic [CW:0]   cols;
  logic          ignore;
  logic          col_wrap;
  logic          out_wrap;

  always_comb begin
    rq = {21'b0, frame_rows};
    if (rq < 32'(VERT_TAPS)) rq = 32'(VERT_TAPS);
    if (rq > 32'(MAX_ROWS)) rq = 32'(MAX_ROWS);
    cq = {21'b0, frame_cols};
    if (cq < 32'(HORIZ_TAPS)) cq = 32'(HORIZ_TAPS);
    if (cq > 32'(MAX_COLS)) cq = 32'(MAX_COLS);
    rows = rq[RW-1:0];
    cols = cq[CW:0];

    ignore = req_type ? (in_row < rows) : (in_row >= rows);
    push   = accept && !ignore;
    col    = in_col;

    ctl.wr   = !req_type;
    ctl.bank = bank;
    if (in_row >= RW'(VHALF) && {1'b0, in_row} < {1'b0, rows} + (RW+1)'(VHALF)) begin
      ctl.vmode = (in_row < RW'(LINE_ROWS) || in_row >= rows) ? VM_EDGE : VM_FILT;
    end else begin
      ctl.vmode = VM_ZERO;
    end
    ctl.emit  = in_row > RW'(VHALF) || (in_row == RW'(VHALF) && in_col >= CW'(HHALF));
    ctl.hedge = out_col < CW'(HHALF) || ({1'b0, out_col} + (CW+1)'(HHALF) >= cols);
    ctl.last  = out_row == rows - RW'(1) && {1'b0, out_col} == cols - (CW+1)'(1);

    col_wrap = {1'b0, in_col} + (CW+1)'(1) >= cols;
    out_wrap = {1'b0, out_col} + (CW+1)'(1) >= cols;
  end

  always_ff @(posedge clk) begin
    if (rst || restart || (push && ctl.emit && ctl.last)) begin
      in_col  <= '0;
      in_row  <= '0;
      bank    <= '0;
      out_col <= '0;
      out_row <= '0;
    end else if (push) begin
      if (col_wrap) begin
        in_col <= '0;
        in_row <= in_row + RW'(1);
        bank   <= bank_add(bank, BANK_W'(1));
      end else begin
        in_col <= in_col + CW'(1);
      end
      if (ctl.emit) begin
        if (out_wrap) begin
          out_col <= '0;
          out_row <= out_row + RW'(1);
        end else begin
          out_col <= out_col + CW'(1);
        end
      end
    end
  end
endmodule

### src/ssm_back.sv
// Back end: six-row line store, vertical and horizontal filter pipelines.
module ssm_back
  import ssm_pkg::*;
#(
  parameter int MAX_COLS = DEF_MAX_COLS
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                q_valid,
  input  logic [$clog2(MAX_COLS)-1:0]         q_col,
  input  ctl_t                                q_ctl,
  input  logic [3*SAMP_W-1:0]                 q_samp,
  output logic                                q_pop,
  input  logic [$clog2(OUT_Q_DEPTH+1)-1:0]    out_level,
  input  logic [63:0]                         vert_taps_lo,
  input  logic [47:0]                         vert_taps_hi,
  input  logic [63:0]                         horiz_taps_lo,
  input  logic signed [TAP_W-1:0]             horiz_tap_four,
  output logic                                res_push,
  output logic [3*PIX_W:0]                    res_data
);
  localparam int LW = $clog2(OUT_Q_DEPTH + 1);

  logic signed [TAP_W-1:0] vtap [VERT_TAPS];
  logic signed [TAP_W-1:0] htap [HORIZ_TAPS];

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      vtap[k] = vert_taps_lo[TAP_W*k +: TAP_W];
      htap[k] = horiz_taps_lo[TAP_W*k +: TAP_W];
    end
    for (int k = 4; k < VERT_TAPS; k++) vtap[k] = vert_taps_hi[TAP_W*(k-4) +: TAP_W];
    htap[4] = horiz_tap_four;
  end

  logic p1_valid, p2_valid, p3_valid, p4_valid, p5_valid, p6_valid;
  ctl_t p1_ctl, p2_ctl, p3_ctl, p4_ctl, p5_ctl;
  logic [3*SAMP_W-1:0] p1_samp;
  logic [2:0] inflight;

  assign inflight = 3'(p1_valid) + 3'(p2_valid) + 3'(p3_valid) + 3'(p4_valid)
                  + 3'(p5_valid) + 3'(p6_valid);
  assign q_pop = q_valid && ({1'b0, out_level} + (LW+1)'(inflight) < (LW+1)'(OUT_Q_DEPTH));

  logic [LINE_ROWS-1:0][3*SAMP_W-1:0] rd_pk;

  for (genvar b = 0; b < LINE_ROWS; b++) begin : g_bank
    logic [3*SAMP_W-1:0] mem [MAX_COLS];
    logic [3*SAMP_W-1:0] rdq;
    always_ff @(posedge clk) begin
      if (q_pop && q_ctl.wr && q_ctl.bank == BANK_W'(b)) mem[q_col] <= q_samp;
      if (q_pop) rdq <= mem[q_col];
    end
    assign rd_pk[b] = rdq;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
      p2_valid <= 1'b0;
      p3_valid <= 1'b0;
      p4_valid <= 1'b0;
      p5_valid <= 1'b0;
      p6_valid <= 1'b0;
    end else begin
      p1_valid <= q_pop;
      p2_valid <= p1_valid;
      p3_valid <= p2_valid;
      p4_valid <= p3_valid;
      p5_valid <= p4_valid;
      p6_valid <= p5_valid && p5_ctl.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      p1_ctl  <= q_ctl;
      p1_samp <= q_samp;
    end
  end

  logic [3*SAMP_W-1:0] vrow [LINE_ROWS];
  logic [3*SAMP_W-1:0] erow;

  always_comb begin
    for (int k = 0; k < LINE_ROWS; k++) vrow[k] = rd_pk[bank_add(p1_ctl.bank, BANK_W'(k))];
    erow = rd_pk[bank_add(p1_ctl.bank, BANK_W'(VHALF))];
  end

  logic signed [VPROD_W-1:0] vprod [3][VERT_TAPS];
  logic [SAMP_W-1:0]         p2_edge [3];

  always_ff @(posedge clk) begin
    if (p1_valid) begin
      p2_ctl <= p1_ctl;
      for (int p = 0; p < 3; p++) begin
        for (int k = 0; k < LINE_ROWS; k++) begin
          vprod[p][k] <= VPROD_W'($signed({1'b0, vrow[k][SAMP_W*p +: SAMP_W]}))
                       * VPROD_W'(vtap[k]);
        end
        vprod[p][VERT_TAPS-1] <= VPROD_W'($signed({1'b0, p1_samp[SAMP_W*p +: SAMP_W]}))
                               * VPROD_W'(vtap[VERT_TAPS-1]);
        p2_edge[p] <= erow[SAMP_W*p +: SAMP_W];
      end
    end
  end

  logic signed [VPART_W-1:0] vpart [3][3];
  logic [SAMP_W-1:0]         p3_edge [3];

  always_ff @(posedge clk) begin
    if (p2_valid) begin
      p3_ctl <= p2_ctl;
      for (int p = 0; p < 3; p++) begin
        vpart[p][0] <= VPART_W'(vprod[p][0]) + VPART_W'(vprod[p][1]);
        vpart[p][1] <= VPART_W'(vprod[p][2]) + VPART_W'(vprod[p][3]);
        vpart[p][2] <= VPART_W'(vprod[p][4]) + VPART_W'(vprod[p][5])
                     + VPART_W'(vprod[p][6]);
        p3_edge[p]  <= p2_edge[p];
      end
    end
  end

  logic signed [PIX_W-1:0]  vnew [3];
  logic signed [VSUM_W-1:0] vsum [3];

  always_comb begin
    for (int p = 0; p < 3; p++) begin
      vsum[p] = VSUM_W'(vpart[p][0]) + VSUM_W'(vpart[p][1]) + VSUM_W'(vpart[p][2]);
      case (p3_ctl.vmode)
        VM_FILT: vnew[p] = round_sat(ACC_W'(vsum[p]));
        VM_EDGE: vnew[p] = {{(PIX_W-SAMP_W){1'b0}}, p3_edge[p]};
        default: vnew[p] = '0;
      endcase
    end
  end

  logic signed [PIX_W-1:0] win [HORIZ_TAPS][3];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < HORIZ_TAPS; k++)
        for (int p = 0; p < 3; p++) win[k][p] <= '0;
    end else if (p3_valid) begin
      for (int k = 0; k < HORIZ_TAPS - 1; k++)
        for (int p = 0; p < 3; p++) win[k][p] <= win[k+1][p];
      for (int p = 0; p < 3; p++) win[HORIZ_TAPS-1][p] <= vnew[p];
    end
  end

  always_ff @(posedge clk) begin
    if (p3_valid) p4_ctl <= p3_ctl;
  end

  logic signed [HPROD_W-1:0] hprod [3][HORIZ_TAPS];
  logic signed [PIX_W-1:0]   hmid [3];

  always_ff @(posedge clk) begin
    if (p4_valid) begin
      p5_ctl <= p4_ctl;
      for (int p = 0; p < 3; p++) begin
        for (int k = 0; k < HORIZ_TAPS; k++)
          hprod[p][k] <= HPROD_W'(win[k][p]) * HPROD_W'(htap[k]);
        hmid[p] <= win[HHALF][p];
      end
    end
  end

  logic signed [HSUM_W-1:0] hsum [3];
  logic signed [PIX_W-1:0]  res [3];
  logic                     res_last;

  always_comb begin
    for (int p = 0; p < 3; p++) begin
      hsum[p] = HSUM_W'(hprod[p][0]) + HSUM_W'(hprod[p][1]) + HSUM_W'(hprod[p][2])
              + HSUM_W'(hprod[p][3]) + HSUM_W'(hprod[p][4]);
    end
  end

  always_ff @(posedge clk) begin
    if (p5_valid) begin
      res_last <= p5_ctl.last;
      for (int p = 0; p < 3; p++)
        res[p] <= p5_ctl.hedge ? hmid[p] : round_sat(ACC_W'(hsum[p]));
    end
  end

  assign res_push = p6_valid;
  assign res_data = {res_last, res[2], res[1], res[0]};
endmodule

### src/separable_smooth_7x5_three_phase.sv
// Top level: 7x5 separable smoothing of three-phase pixels, front end, queues and back end.
// Path: an accepted pixel's result transfer is offered after the command queue, six pipeline
// stages and the output queue, for the item 3*cols+2 behind.
// Throughput: one item per cycle while the output queue has room; each row bank's single
// write and read port and the 21 vertical and 15 horizontal multipliers serve one item a cycle.
// Reset: counters, queues and filter window clear; registers take their reset values; the
// line store holds no data until written and needs no clearing pass.
module separable_smooth_7x5_three_phase
  import ssm_pkg::*;
#(
  parameter int MAX_COLS = DEF_MAX_COLS,
  parameter int MAX_ROWS = DEF_MAX_ROWS
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         req_type,
  input  logic [SAMP_W-1:0]            phase_zero,
  input  logic [SAMP_W-1:0]            phase_one,
  input  logic [SAMP_W-1:0]            phase_two,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [PIX_W-1:0]      smooth_zero,
  output logic signed [PIX_W-1:0]      smooth_one,
  output logic signed [PIX_W-1:0]      smooth_two,
  output logic                         frame_end,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [CFG_IDX_W-1:0]         cfg_index,
  input  logic [CFG_DATA_W-1:0]        cfg_data
);
  localparam int CW  = $clog2(MAX_COLS);
  localparam int QW  = CW + $bits(ctl_t) + 3*SAMP_W;
  localparam int OW  = 3*PIX_W + 1;

  logic [DIM_W-1:0]        frame_rows;
  logic [DIM_W-1:0]        frame_cols;
  logic [63:0]             vert_taps_lo;
  logic [47:0]             vert_taps_hi;
  logic [63:0]             horiz_taps_lo;
  logic signed [TAP_W-1:0] horiz_tap_four;

  logic cfg_fire;
  logic restart;

  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign restart   = cfg_fire && (cfg_index == REG_FRAME_ROWS || cfg_index == REG_FRAME_COLS);

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_rows     <= RST_FRAME_ROWS;
      frame_cols     <= RST_FRAME_COLS;
      vert_taps_lo   <= RST_VERT_LO;
      vert_taps_hi   <= RST_VERT_HI;
      horiz_taps_lo  <= RST_HORIZ_LO;
      horiz_tap_four <= RST_HORIZ_FOUR;
    end else if (cfg_fire) begin
      case (cfg_index)
        REG_FRAME_ROWS:     frame_rows     <= cfg_data[DIM_W-1:0];
        REG_FRAME_COLS:     frame_cols     <= cfg_data[DIM_W-1:0];
        REG_VERT_TAPS_LO:   vert_taps_lo   <= cfg_data;
        REG_VERT_TAPS_HI:   vert_taps_hi   <= cfg_data[47:0];
        REG_HORIZ_TAPS_LO:  horiz_taps_lo  <= cfg_data;
        REG_HORIZ_TAP_FOUR: horiz_tap_four <= cfg_data[TAP_W-1:0];
        default: ;
      endcase
    end
  end

  logic          f_push;
  ctl_t          f_ctl;
  logic [CW-1:0] f_col;

  ssm_front #(
    .MAX_COLS(MAX_COLS),
    .MAX_ROWS(MAX_ROWS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .restart    (restart),
    .frame_rows (frame_rows),
    .frame_cols (frame_cols),
    .accept     (in_valid && !in_stall),
    .req_type   (req_type),
    .push       (f_push),
    .ctl        (f_ctl),
    .col        (f_col)
  );

  logic [QW-1:0]                   q_head;
  logic [$clog2(IN_Q_DEPTH+1)-1:0] q_count;
  logic                            q_full;
  logic                            q_empty;
  logic                            q_pop;

  ssm_fifo #(
    .W    (QW),
    .DEPTH(IN_Q_DEPTH)
  ) u_cmd_q (
    .clk       (clk),
    .rst       (rst),
    .push      (f_push),
    .push_data ({f_col, f_ctl, phase_two, phase_one, phase_zero}),
    .pop       (q_pop),
    .head      (q_head),
    .count     (q_count),
    .full      (q_full),
    .empty     (q_empty)
  );

  assign in_stall = q_full;

  logic                             res_push;
  logic [OW-1:0]                    res_data;
  logic [OW-1:0]                    o_head;
  logic [$clog2(OUT_Q_DEPTH+1)-1:0] o_count;
  logic                             o_full;
  logic                             o_empty;

  ssm_back #(
    .MAX_COLS(MAX_COLS)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .q_valid        (!q_empty && q_count != '0),
    .q_col          (q_head[QW-1 -: CW]),
    .q_ctl          (q_head[3*SAMP_W +: $bits(ctl_t)]),
    .q_samp         (q_head[3*SAMP_W-1:0]),
    .q_pop          (q_pop),
    .out_level      (o_count),
    .vert_taps_lo   (vert_taps_lo),
    .vert_taps_hi   (vert_taps_hi),
    .horiz_taps_lo  (horiz_taps_lo),
    .horiz_tap_four (horiz_tap_four),
    .res_push       (res_push),
    .res_data       (res_data)
  );

  ssm_fifo #(
    .W    (OW),
    .DEPTH(OUT_Q_DEPTH)
  ) u_out_q (
    .clk       (clk),
    .rst       (rst),
    .push      (res_push),
    .push_data (res_data),
    .pop       (out_valid && !out_stall),
    .head      (o_head),
    .count     (o_count),
    .full      (o_full),
    .empty     (o_empty)
  );

  assign out_valid   = !o_empty;
  assign smooth_zero = o_head[PIX_W-1:0];
  assign smooth_one  = o_head[2*PIX_W-1:PIX_W];
  assign smooth_two  = o_head[3*PIX_W-1:2*PIX_W];
  assign frame_end   = o_head[3*PIX_W];

`ifndef SYNTHESIS
  // The back end must only take a command that the queue actually holds.
  assert property (@(posedge clk) disable iff (rst) q_pop |-> !q_empty)
    else $error("command queue read while empty");

  // The credit check must keep the output queue from overflowing.
  assert property (@(posedge clk) disable iff (rst) res_push |-> !o_full)
    else $error("result written to a full output queue");

  // A frame size write restarts the frame, so nothing may then be in flight.
  assert property (@(posedge clk) disable iff (rst) restart |-> q_empty && o_empty)
    else $error("frame size written while transfers are pending");
`endif
endmodule

### dv/tb_separable_smooth_7x5_three_phase.sv
// Self-checking testbench for the separable 7x5 three-phase smoothing filter.
module tb_separable_smooth_7x5_three_phase;
  import ssm_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;
  localparam bit REQ_PIXEL = 1'b0;
  localparam bit REQ_DRAIN = 1'b1;
  localparam int SETTLE_CYCLES = 24;

  typedef struct {
    logic signed [PIX_W-1:0] s0;
    logic signed [PIX_W-1:0] s1;
    logic signed [PIX_W-1:0] s2;
    logic                    fe;
  } smooth_t;

  typedef struct {
    bit          rq;
    bit [11:0]   a;
    bit [11:0]   b;
    bit [11:0]   c;
    bit          typed;
    smooth_t     want;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic req_type = 1'b0;
  logic [SAMP_W-1:0] phase_zero = '0, phase_one = '0, phase_two = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [PIX_W-1:0] smooth_zero, smooth_one, smooth_two;
  logic frame_end;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  separable_smooth_7x5_three_phase u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .req_type(req_type),
    .phase_zero(phase_zero), .phase_one(phase_one), .phase_two(phase_two),
    .out_valid(out_valid), .out_stall(out_stall),
    .smooth_zero(smooth_zero), .smooth_one(smooth_one), .smooth_two(smooth_two),
    .frame_end(frame_end),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // Filter state mirrored on the testbench side.
  bit [10:0] m_rows, m_cols;
  bit [63:0] m_vlo, m_hlo;
  bit [47:0] m_vhi;
  bit [15:0] m_hfour;
  bit [11:0] lstore [6144][3];
  int        hwin [5][3];
  int        pos_in_row, pos_in_col, pos_out_row, pos_out_col;
  bit        frame_done;

  smooth_t   smooth_q[$];
  int        errors = 0;
  int        n_items = 0, n_results = 0, n_frames = 0, n_configs = 0;
  int        burst_left = 0;

  function automatic int used_rows();
    return (m_rows < 7) ? 7 : (m_rows > 1024) ? 1024 : int'(m_rows);
  endfunction

  function automatic int used_cols();
    return (m_cols < 5) ? 5 : (m_cols > 1024) ? 1024 : int'(m_cols);
  endfunction

  function automatic longint vtap(int k);
    if (k < 4) return longint'($signed(m_vlo[16*k +: 16]));
    return longint'($signed(m_vhi[16*(k-4) +: 16]));
  endfunction

  function automatic longint htap(int k);
    if (k < 4) return longint'($signed(m_hlo[16*k +: 16]));
    return longint'($signed(m_hfour));
  endfunction

  function automatic int round_clip(longint acc);
    longint q;
    q = (acc + 64'sd8192) >>> 14;
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    return int'(q);
  endfunction

  function automatic void restart_frame();
    pos_in_row = 0; pos_in_col = 0; pos_out_row = 0; pos_out_col = 0;
  endfunction

  function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] val);
    case (idx)
      REG_FRAME_ROWS:     begin m_rows = val[10:0]; restart_frame(); end
      REG_FRAME_COLS:     begin m_cols = val[10:0]; restart_frame(); end
      REG_VERT_TAPS_LO:   m_vlo = val;
      REG_VERT_TAPS_HI:   m_vhi = val[47:0];
      REG_HORIZ_TAPS_LO:  m_hlo = val;
      REG_HORIZ_TAP_FOUR: m_hfour = val[15:0];
      default: ;
    endcase
  endfunction

  // Advances the mirrored filter by one accepted item and queues the smoothed pixel, if any.
  function automatic void smooth_step(bit drain, bit [11:0] a, bit [11:0] b, bit [11:0] c);
    int rows, cols, col, rv, row, base;
    int samp[3], vnew[3], res[3];
    longint acc;
    bit emit, last;
    smooth_t r;
    rows = used_rows();
    cols = used_cols();
    if (drain ? (pos_in_row < rows) : (pos_in_row >= rows)) return;
    col = (pos_in_col >= cols) ? cols - 1 : pos_in_col;
    samp[0] = a; samp[1] = b; samp[2] = c;
    vnew = '{0, 0, 0};
    if (pos_in_row >= VHALF && pos_in_row - VHALF < rows) begin
      rv = pos_in_row - VHALF;
      if (rv < VHALF || rv + VHALF >= rows) begin
        for (int p = 0; p < 3; p++) vnew[p] = lstore[(rv % LINE_ROWS) * 1024 + col][p];
      end else begin
        for (int p = 0; p < 3; p++) begin
          acc = 0;
          for (int k = 0; k < VERT_TAPS; k++) begin
            row = rv - VHALF + k;
            if (k == VERT_TAPS - 1) acc += longint'(samp[p]) * vtap(k);
            else acc += longint'(lstore[(row % LINE_ROWS) * 1024 + col][p]) * vtap(k);
          end
          vnew[p] = round_clip(acc);
        end
      end
    end
    if (!drain) begin
      base = (pos_in_row % LINE_ROWS) * 1024 + col;
      for (int p = 0; p < 3; p++) lstore[base][p] = samp[p][11:0];
    end
    for (int k = 0; k < HORIZ_TAPS - 1; k++) hwin[k] = hwin[k+1];
    for (int p = 0; p < 3; p++) hwin[HORIZ_TAPS-1][p] = vnew[p];
    emit = longint'(pos_in_row) * cols + col >= longint'(VHALF) * cols + HHALF;
    if (col + 1 >= cols) begin
      pos_in_col = 0; pos_in_row = pos_in_row + 1;
    end else begin
      pos_in_col = col + 1;
    end
    if (!emit) return;
    for (int p = 0; p < 3; p++) begin
      if (pos_out_col < HHALF || pos_out_col + HHALF >= cols) begin
        res[p] = hwin[HHALF][p];
      end else begin
        acc = 0;
        for (int k = 0; k < HORIZ_TAPS; k++) acc += longint'(hwin[k][p]) * htap(k);
        res[p] = round_clip(acc);
      end
    end
    last = (pos_out_row == rows - 1) && (pos_out_col == cols - 1);
    r.s0 = res[0][15:0]; r.s1 = res[1][15:0]; r.s2 = res[2][15:0]; r.fe = last;
    smooth_q.push_back(r);
    if (pos_out_col + 1 >= cols) begin
      pos_out_col = 0; pos_out_row++;
    end else begin
      pos_out_col++;
    end
    if (last) begin
      restart_frame();
      frame_done = 1'b1;
      n_frames++;
    end
  endfunction

  task automatic send_item(bit rq, bit [11:0] a, bit [11:0] b, bit [11:0] c);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_valid = 1'b1;
    req_type = rq;
    phase_zero = a; phase_one = b; phase_two = c;
    do @(posedge clk); while (in_stall);
    smooth_step(rq, a, b, c);
    n_items++;
    @(negedge clk);
  endtask

  task automatic wait_idle();
    in_valid = 1'b0;
    while (smooth_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] val);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    do @(posedge clk); while (!cfg_ready);
    apply_reg(idx, val);
    n_configs++;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  function automatic bit [11:0] rand_sample();
    case ($urandom_range(0, 7))
      0: return 12'h000;
      1: return 12'hfff;
      default: return 12'($urandom);
    endcase
  endfunction

  function automatic logic [63:0] rand_taps(int style);
    logic [63:0] v;
    for (int k = 0; k < 4; k++) begin
      case (style)
        0: v[16*k +: 16] = 16'($urandom_range(0, 4096));
        1: v[16*k +: 16] = ($urandom_range(0, 1) == 1) ? 16'h7fff : 16'h8000;
        default: v[16*k +: 16] = 16'($urandom);
      endcase
    end
    return v;
  endfunction

  // Runs the current frame to its end; ignored requests of the wrong kind are mixed in at noise_pct.
  task automatic finish_frame(int noise_pct);
    bit want_drain;
    frame_done = 1'b0;
    while (!frame_done) begin
      want_drain = (pos_in_row >= used_rows());
      if ($urandom_range(0, 99) < noise_pct) want_drain = !want_drain;
      send_item(want_drain, rand_sample(), rand_sample(), rand_sample());
    end
  endtask

  task automatic random_setting(int rows, int cols, int style);
    write_reg(REG_FRAME_ROWS, 64'(rows));
    write_reg(REG_FRAME_COLS, 64'(cols));
    write_reg(REG_VERT_TAPS_LO, rand_taps(style));
    write_reg(REG_VERT_TAPS_HI, rand_taps(style) & 64'hffff_ffff_ffff);
    write_reg(REG_HORIZ_TAPS_LO, rand_taps(style));
    write_reg(REG_HORIZ_TAP_FOUR, rand_taps(style) & 64'hffff);
  endtask

  // Receiver stall pattern: its character is redrawn whenever stall_count runs out.
  int stall_mode = 0, stall_count = 0;
  always @(negedge clk) begin
    if (stall_count == 0) begin
      stall_mode = $urandom_range(0, 2);
      stall_count = 48;
    end
    stall_count--;
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      default: out_stall <= ($urandom_range(0, 1) == 1);
    endcase
  end

  always @(posedge clk) begin
    smooth_t w;
    if (!rst && out_valid && !out_stall) begin
      if (smooth_q.size() == 0) begin
        $display("%0t: unexpected transfer %0d %0d %0d end %0b", $time,
                 smooth_zero, smooth_one, smooth_two, frame_end);
        errors++;
      end else begin
        w = smooth_q.pop_front();
        n_results++;
        if (smooth_zero !== w.s0 || smooth_one !== w.s1 || smooth_two !== w.s2 ||
            frame_end !== w.fe) begin
          $display("%0t: expected %0d %0d %0d end %0b, got %0d %0d %0d end %0b", $time,
                   w.s0, w.s1, w.s2, w.fe, smooth_zero, smooth_one, smooth_two, frame_end);
          errors++;
        end
      end
    end
  end

  initial begin
    #3_000_000;
    $display("tb_separable_smooth_7x5_three_phase: FAIL");
    $finish;
  end

  dir_row_t dir_tab[24];

  initial begin
    int before_q;
    m_rows = RST_FRAME_ROWS; m_cols = RST_FRAME_COLS;
    m_vlo = RST_VERT_LO; m_vhi = RST_VERT_HI; m_hlo = RST_HORIZ_LO; m_hfour = RST_HORIZ_FOUR;
    foreach (hwin[k, p]) hwin[k][p] = 0;
    restart_frame();

    // Identity taps on a minimum 7x5 frame: each output is the raw pixel 17 places back.
    dir_tab[0] = '{REQ_DRAIN, 12'h000, 12'h000, 12'h000, 1'b0, '{0, 0, 0, 0}};
    dir_tab[1] = '{REQ_PIXEL, 12'h000, 12'h000, 12'h000, 1'b0, '{0, 0, 0, 0}};
    dir_tab[2] = '{REQ_PIXEL, 12'hfff, 12'hfff, 12'hfff, 1'b0, '{0, 0, 0, 0}};
    dir_tab[3] = '{REQ_PIXEL, 12'haaa, 12'h555, 12'h800, 1'b0, '{0, 0, 0, 0}};
    dir_tab[4] = '{REQ_PIXEL, 12'h555, 12'haaa, 12'h001, 1'b0, '{0, 0, 0, 0}};
    dir_tab[5] = '{REQ_PIXEL, 12'h7ff, 12'h800, 12'hfff, 1'b0, '{0, 0, 0, 0}};
    dir_tab[6] = '{REQ_PIXEL, 12'h123, 12'h456, 12'h789, 1'b0, '{0, 0, 0, 0}};
    for (int i = 7; i < 18; i++)
      dir_tab[i] = '{REQ_PIXEL, 12'(i * 331), 12'(4095 - i * 97), 12'(i * 13), 1'b0,
                     '{0, 0, 0, 0}};
    dir_tab[18] = '{REQ_PIXEL, 12'hf0f, 12'h0f0, 12'h3c3, 1'b1, '{0, 0, 0, 0}};
    dir_tab[19] = '{REQ_PIXEL, 12'h00f, 12'hf00, 12'h0c0, 1'b1, '{4095, 4095, 4095, 0}};
    dir_tab[20] = '{REQ_PIXEL, 12'h001, 12'h002, 12'h004, 1'b1, '{12'haaa, 12'h555, 12'h800, 0}};
    dir_tab[21] = '{REQ_PIXEL, 12'h008, 12'h010, 12'h020, 1'b1, '{12'h555, 12'haaa, 12'h001, 0}};
    dir_tab[22] = '{REQ_PIXEL, 12'h040, 12'h080, 12'h100, 1'b1, '{12'h7ff, 12'h800, 12'hfff, 0}};
    dir_tab[23] = '{REQ_PIXEL, 12'h200, 12'h400, 12'hfff, 1'b1, '{12'h123, 12'h456, 12'h789, 0}};

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    repeat (4) @(negedge clk);

    write_reg(REG_FRAME_ROWS, 64'd0);
    write_reg(REG_FRAME_COLS, 64'd0);
    foreach (dir_tab[i]) begin
      before_q = smooth_q.size();
      send_item(dir_tab[i].rq, dir_tab[i].a, dir_tab[i].b, dir_tab[i].c);
      if (dir_tab[i].typed && (smooth_q.size() != before_q + 1 || smooth_q[$] != dir_tab[i].want))
      begin
        $display("%0t: row %0d expected %0d %0d %0d end %0b", $time, i, dir_tab[i].want.s0,
                 dir_tab[i].want.s1, dir_tab[i].want.s2, dir_tab[i].want.fe);
        errors++;
      end
    end
    finish_frame(0);

    // Random frames: small sizes, clamped sizes and a range of tap styles.
    for (int ph = 0; ph < 4; ph++) begin
      wait_idle();
      case (ph)
        0: random_setting(1, 3, 0);
        1: random_setting($urandom_range(7, 10), $urandom_range(5, 9), 0);
        2: random_setting($urandom_range(7, 9), $urandom_range(5, 8), 1);
        3: random_setting($urandom_range(8, 10), $urandom_range(6, 9), 2);
        default: random_setting($urandom_range(7, 10), $urandom_range(5, 9), $urandom_range(0, 2));
      endcase
      write_reg(REG_SPARE_LO, {$urandom, $urandom});
      finish_frame(ph == 0 ? 0 : 6);
    end

    // Partial frame abandoned by a size write, then a row count clamped from above.
    for (int i = 0; i < 24; i++) send_item(REQ_PIXEL, rand_sample(), rand_sample(), rand_sample());
    wait_idle();
    random_setting(2047, 10, 1);
    write_reg(REG_SPARE_HI, 64'hffff_ffff_ffff_ffff);
    for (int i = 0; i < 3 * 10 + 20; i++)
      send_item(REQ_PIXEL, rand_sample(), rand_sample(), rand_sample());
    wait_idle();
    random_setting(7, 5, 2);
    write_reg(REG_VERT_TAPS_LO, 64'hffff_ffff_ffff_ffff);
    write_reg(REG_HORIZ_TAP_FOUR, 64'h0000_0000_0000_7fff);
    finish_frame(4);

    wait_idle();
    $display("Covered %0d accepted items, %0d result transfers, %0d complete frames,",
             n_items, n_results, n_frames);
    $display("%0d register writes, minimum frame sizes and sizes clamped from both sides.",
             n_configs);
    if (errors == 0) begin
      $display("tb_separable_smooth_7x5_three_phase: PASS");
    end else begin
      $display("tb_separable_smooth_7x5_three_phase: FAIL");
    end
    $finish;
  end

endmodule
